// ----- rtl/vlsm_subnet_planner_macros.svh -----
// Assertion macros shared by the subnet planner modules.
// Plain text, no dependencies; pulled in by the modules that check themselves.
`ifndef VLSM_SUBNET_PLANNER_MACROS_SVH
`define VLSM_SUBNET_PLANNER_MACROS_SVH

// same-cycle implication
`define VSP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("vsp check failed");

// next-cycle implication
`define VSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("vsp check failed");

`endif

// ----- rtl/vsp_pkg.sv -----
// Shared constants, types and the block-size rounding function for the subnet planner.
// No dependencies.
package vsp_pkg;

    localparam int MAX_SUBNETS = 32;
    localparam int CNT_W       = $clog2(MAX_SUBNETS + 1);
    localparam int HOST_W      = 24;
    localparam int ADDR_W      = 32;
    localparam int PREFIX_W    = 5;
    localparam int IDX_W       = 6;
    localparam int EXP_W       = 5;
    localparam int NUM_EXP     = 1 << EXP_W;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LEN = 1'd1;
    localparam logic [PREFIX_W-1:0]  PREFIX_RESET   = 5'd24;

    typedef struct packed {
        logic load_req;
        logic plan_init;
        logic next_exp;
        logic emit;
        logic emit_fail;
        logic clear;
    } vsp_cmd_t;

    typedef struct packed {
        logic fits;
        logic bucket_done;
        logic last_item;
        logic out_free;
    } vsp_status_t;

    // smallest e with 2^e >= hosts + 2, i.e. bit length of hosts + 1
    function automatic logic [EXP_W-1:0] round_exp(input logic [HOST_W-1:0] hosts);
        logic [HOST_W:0]    v;
        logic [EXP_W-1:0]   e;
        v = (HOST_W + 1)'(hosts) + (HOST_W + 1)'(1);
        e = '0;
        for (int i = 0; i <= HOST_W; i++)
        begin
            if (v[i])
            begin
                e = EXP_W'(i + 1);
            end
        end
        return e;
    endfunction

endpackage

// ----- rtl/vsp_ctrl.sv -----
// Planner controller: request intake, fit check, bucket scan and result issue.
// Depends on vsp_pkg and vlsm_subnet_planner_macros.svh.
`include "vlsm_subnet_planner_macros.svh"

module vsp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 last_request,
    output logic                 req_stall,
    input  vsp_pkg::vsp_status_t status,
    output vsp_pkg::vsp_cmd_t    cmd
);
    import vsp_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_FAIL  = 2'd2;
    localparam logic [1:0] ST_SCAN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    if (last_request)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                cmd.plan_init = 1'b1;
                state_next    = status.fits ? ST_SCAN : ST_FAIL;
            end
            ST_FAIL:
            begin
                if (status.out_free)
                begin
                    cmd.emit_fail = 1'b1;
                    cmd.clear     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                // empty or finished bucket: step down to the next exponent
                if (status.bucket_done)
                begin
                    cmd.next_exp = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_item)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `VSP_ASSERT_NEXT(a_last_starts_check, clk, rst_n, req_valid && !req_stall && last_request, state_reg == ST_CHECK)
    `VSP_ASSERT_NOW(a_issue_needs_slot, clk, rst_n, cmd.emit || cmd.emit_fail, status.out_free)
    `VSP_ASSERT_NEXT(a_clear_returns_idle, clk, rst_n, cmd.clear, state_reg == ST_IDLE && !req_stall)

endmodule

// ----- rtl/vsp_datapath.sv -----
// Planner datapath: config registers, per-exponent counts, running sum, address
// generation and the result register. Depends on vsp_pkg and the macros header.
`include "vlsm_subnet_planner_macros.svh"

module vsp_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vsp_pkg::ADDR_W-1:0]    cfg_data,
    input  logic [vsp_pkg::HOST_W-1:0]    host_count,
    input  vsp_pkg::vsp_cmd_t             cmd,
    output vsp_pkg::vsp_status_t          status,
    input  logic                          res_stall,
    output logic                          res_valid,
    output logic [vsp_pkg::IDX_W-1:0]     subnet_index,
    output logic [vsp_pkg::ADDR_W-1:0]    network_addr,
    output logic [vsp_pkg::ADDR_W-1:0]    first_host,
    output logic [vsp_pkg::ADDR_W-1:0]    final_host,
    output logic [vsp_pkg::ADDR_W-1:0]    broadcast_addr,
    output logic [vsp_pkg::ADDR_W-1:0]    subnet_mask,
    output logic                          fits,
    output logic                          overflowed,
    output logic                          end_of_plan
);
    import vsp_pkg::*;

    logic [ADDR_W-1:0]   base_reg;
    logic [PREFIX_W-1:0] prefix_reg;

    logic [CNT_W-1:0]    req_cnt_reg;
    logic [ADDR_W-1:0]   sum_reg;
    logic                ovf_reg;
    logic [CNT_W-1:0]    bucket_reg [NUM_EXP];

    logic [EXP_W-1:0]    scan_exp_reg;
    logic [CNT_W-1:0]    done_cnt_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [ADDR_W-1:0]   addr_reg;

    logic                res_valid_reg;
    logic [IDX_W-1:0]    index_reg;
    logic [ADDR_W-1:0]   net_reg;
    logic [ADDR_W-1:0]   first_reg;
    logic [ADDR_W-1:0]   final_reg;
    logic [ADDR_W-1:0]   bcast_reg;
    logic [ADDR_W-1:0]   mask_reg;
    logic                fits_reg;
    logic                ovf_out_reg;
    logic                end_reg;

    logic [EXP_W-1:0]    req_exp;
    logic                store_ok;
    logic [PREFIX_W:0]   host_bits;
    logic [ADDR_W:0]     capacity;
    logic [ADDR_W-1:0]   net_mask;
    logic [ADDR_W-1:0]   block;
    logic [CNT_W-1:0]    idx_inc;

    assign req_exp   = round_exp(host_count);
    assign store_ok  = (req_cnt_reg < CNT_W'(MAX_SUBNETS));
    assign host_bits = (PREFIX_W + 1)'(ADDR_W) - {1'b0, prefix_reg};
    assign capacity  = (ADDR_W + 1)'(1) << host_bits;
    assign net_mask  = (host_bits >= (PREFIX_W + 1)'(ADDR_W)) ? '0 : ('1 << host_bits);
    assign block     = ADDR_W'(1) << scan_exp_reg;
    assign idx_inc   = idx_reg + CNT_W'(1);

    assign status.fits        = ({1'b0, sum_reg} <= capacity);
    assign status.bucket_done = (done_cnt_reg == bucket_reg[scan_exp_reg]);
    assign status.last_item   = (idx_inc == req_cnt_reg);
    assign status.out_free    = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            prefix_reg <= PREFIX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_ADDR:  base_reg   <= cfg_data;
                REG_PREFIX_LEN: prefix_reg <= cfg_data[PREFIX_W-1:0];
                default:        ;
            endcase
        end
    end

    // request accumulation; counts per exponent give the largest-first order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_cnt_reg <= '0;
            sum_reg     <= '0;
            ovf_reg     <= 1'b0;
            for (int i = 0; i < NUM_EXP; i++)
            begin
                bucket_reg[i] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            req_cnt_reg <= '0;
            sum_reg     <= '0;
            ovf_reg     <= 1'b0;
            for (int i = 0; i < NUM_EXP; i++)
            begin
                bucket_reg[i] <= '0;
            end
        end
        else if (cmd.load_req)
        begin
            if (store_ok)
            begin
                req_cnt_reg <= req_cnt_reg + CNT_W'(1);
                sum_reg     <= sum_reg + (ADDR_W'(1) << req_exp);
                for (int i = 0; i < NUM_EXP; i++)
                begin
                    if (req_exp == EXP_W'(i))
                    begin
                        bucket_reg[i] <= bucket_reg[i] + CNT_W'(1);
                    end
                end
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_exp_reg <= '0;
            done_cnt_reg <= '0;
            idx_reg      <= '0;
            addr_reg     <= '0;
        end
        else if (cmd.plan_init)
        begin
            scan_exp_reg <= '1;
            done_cnt_reg <= '0;
            idx_reg      <= '0;
            addr_reg     <= base_reg & net_mask;
        end
        else if (cmd.next_exp)
        begin
            scan_exp_reg <= scan_exp_reg - EXP_W'(1);
            done_cnt_reg <= '0;
        end
        else if (cmd.emit)
        begin
            done_cnt_reg <= done_cnt_reg + CNT_W'(1);
            idx_reg      <= idx_inc;
            addr_reg     <= addr_reg + block;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.emit_fail)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            index_reg   <= IDX_W'(idx_reg);
            net_reg     <= addr_reg;
            first_reg   <= addr_reg + ADDR_W'(1);
            final_reg   <= addr_reg + (block - ADDR_W'(2));
            bcast_reg   <= addr_reg + (block - ADDR_W'(1));
            mask_reg    <= ~(block - ADDR_W'(1));
            fits_reg    <= 1'b1;
            ovf_out_reg <= ovf_reg;
            end_reg     <= status.last_item;
        end
        else if (cmd.emit_fail)
        begin
            index_reg   <= '0;
            net_reg     <= '0;
            first_reg   <= '0;
            final_reg   <= '0;
            bcast_reg   <= '0;
            mask_reg    <= '0;
            fits_reg    <= 1'b0;
            ovf_out_reg <= ovf_reg;
            end_reg     <= 1'b1;
        end
    end

    assign res_valid      = res_valid_reg;
    assign subnet_index   = index_reg;
    assign network_addr   = net_reg;
    assign first_host     = first_reg;
    assign final_host     = final_reg;
    assign broadcast_addr = bcast_reg;
    assign subnet_mask    = mask_reg;
    assign fits           = fits_reg;
    assign overflowed     = ovf_out_reg;
    assign end_of_plan    = end_reg;

    `VSP_ASSERT_NOW(a_count_bounded, clk, rst_n, 1'b1, req_cnt_reg <= CNT_W'(MAX_SUBNETS))
    `VSP_ASSERT_NOW(a_emit_from_bucket, clk, rst_n, cmd.emit, done_cnt_reg < bucket_reg[scan_exp_reg])
    `VSP_ASSERT_NEXT(a_clear_empties, clk, rst_n, cmd.clear, req_cnt_reg == '0 && sum_reg == '0 && !ovf_reg)
    `VSP_ASSERT_NEXT(a_issue_shows, clk, rst_n, cmd.emit || cmd.emit_fail, res_valid_reg)

endmodule

// ----- rtl/vlsm_subnet_planner.sv -----
// Requests are taken one per cycle while the planner is idle (req_stall low); the request
// marked last is followed by a fit check, then one result per cycle within a bucket, with
// a step for each exponent bucket passed on the way down from 2^31 to the smallest block
// used, all stretched by result stalls.
// Reset (async, rst_n low) empties the request store, drops any pending result and sets
// base_addr to 0 and prefix_len to 24.
module vlsm_subnet_planner (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vsp_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [vsp_pkg::HOST_W-1:0]    host_count,
    input  logic                          last_request,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [vsp_pkg::IDX_W-1:0]     subnet_index,
    output logic [vsp_pkg::ADDR_W-1:0]    network_addr,
    output logic [vsp_pkg::ADDR_W-1:0]    first_host,
    output logic [vsp_pkg::ADDR_W-1:0]    final_host,
    output logic [vsp_pkg::ADDR_W-1:0]    broadcast_addr,
    output logic [vsp_pkg::ADDR_W-1:0]    subnet_mask,
    output logic                          fits,
    output logic                          overflowed,
    output logic                          end_of_plan
);
    import vsp_pkg::*;

    vsp_cmd_t    cmd;
    vsp_status_t status;

    vsp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .last_request (last_request),
        .req_stall    (req_stall),
        .status       (status),
        .cmd          (cmd)
    );

    vsp_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .host_count     (host_count),
        .cmd            (cmd),
        .status         (status),
        .res_stall      (res_stall),
        .res_valid      (res_valid),
        .subnet_index   (subnet_index),
        .network_addr   (network_addr),
        .first_host     (first_host),
        .final_host     (final_host),
        .broadcast_addr (broadcast_addr),
        .subnet_mask    (subnet_mask),
        .fits           (fits),
        .overflowed     (overflowed),
        .end_of_plan    (end_of_plan)
    );

endmodule

// ----- verif/vlsm_subnet_planner_tb.sv -----
// Self-checking bench for vlsm_subnet_planner: queued subnet requests, random flow control,
// and a built-in planner that predicts every subnet result. Depends on rtl/vsp_pkg.sv
// and rtl/vlsm_subnet_planner.sv.
module vlsm_subnet_planner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vsp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS = 400;

    typedef struct packed {
        logic [HOST_W-1:0] hosts;
        logic              last;
    } subnet_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] net_addr;
        logic [ADDR_W-1:0] lo_host;
        logic [ADDR_W-1:0] hi_host;
        logic [ADDR_W-1:0] bcast;
        logic [ADDR_W-1:0] mask;
        logic              fit;
        logic              ovf;
        logic              eop;
    } subnet_res_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data = '0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic [HOST_W-1:0]    host_count = '0;
    logic                 last_request = 1'b0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic [IDX_W-1:0]     subnet_index;
    logic [ADDR_W-1:0]    network_addr;
    logic [ADDR_W-1:0]    first_host;
    logic [ADDR_W-1:0]    final_host;
    logic [ADDR_W-1:0]    broadcast_addr;
    logic [ADDR_W-1:0]    subnet_mask;
    logic                 fits;
    logic                 overflowed;
    logic                 end_of_plan;

    vlsm_subnet_planner dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .host_count     (host_count),
        .last_request   (last_request),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .subnet_index   (subnet_index),
        .network_addr   (network_addr),
        .first_host     (first_host),
        .final_host     (final_host),
        .broadcast_addr (broadcast_addr),
        .subnet_mask    (subnet_mask),
        .fits           (fits),
        .overflowed     (overflowed),
        .end_of_plan    (end_of_plan)
    );

    // planner copy: configuration and request store
    logic [ADDR_W-1:0]   plan_base = '0;
    logic [PREFIX_W-1:0] plan_prefix = PREFIX_RESET;
    logic [EXP_W-1:0]    blk_exp [MAX_SUBNETS];
    int unsigned         stored_cnt = 0;
    logic [ADDR_W-1:0]   space_total = '0;
    logic                dropped = 1'b0;

    subnet_req_t req_q [$];
    subnet_res_t subnet_plan_q [$];

    int          mismatch_cnt = 0;
    int unsigned cycles = 0;
    int unsigned results_seen = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left = 0;
    subnet_req_t next_req;
    subnet_res_t want;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // smallest exponent whose block holds hosts plus network and broadcast
    function automatic logic [EXP_W-1:0] block_exp_of(input logic [HOST_W-1:0] hosts);
        logic [32:0] need;
        int unsigned e;
        need = 33'(hosts) + 33'd2;
        e = 0;
        while (e < 31 && (33'd1 << e) < need)
            e++;
        return EXP_W'(e);
    endfunction

    task automatic plan_request(input logic [HOST_W-1:0] hosts, input logic last);
        int unsigned       host_bits;
        longint unsigned   capacity;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] blk;
        int unsigned       produced;
        subnet_res_t       r;
        logic [EXP_W-1:0]  e_new;
        int                e;
        int unsigned       k;
        if (stored_cnt < MAX_SUBNETS)
        begin
            e_new = block_exp_of(hosts);
            blk_exp[stored_cnt] = e_new;
            stored_cnt++;
            space_total = space_total + (32'd1 << e_new);
        end
        else
            dropped = 1'b1;
        if (!last)
            return;
        host_bits = 32 - plan_prefix;
        capacity = 64'd1 << host_bits;
        if (64'(space_total) > capacity)
        begin
            r = '0;
            r.ovf = dropped;
            r.eop = 1'b1;
            subnet_plan_q.push_back(r);
        end
        else
        begin
            addr = (host_bits >= 32) ? '0 : (plan_base & (32'hFFFF_FFFF << host_bits));
            produced = 0;
            for (e = 31; e >= 0; e--)
            begin
                for (k = 0; k < stored_cnt; k++)
                begin
                    if (blk_exp[k] == EXP_W'(e))
                    begin
                        blk = 32'd1 << e;
                        r.idx = IDX_W'(produced);
                        r.net_addr = addr;
                        r.lo_host = addr + 32'd1;
                        r.bcast = addr + blk - 32'd1;
                        r.hi_host = r.bcast - 32'd1;
                        r.mask = 32'hFFFF_FFFF - (blk - 32'd1);
                        r.fit = 1'b1;
                        r.ovf = dropped;
                        r.eop = (produced + 1 == stored_cnt);
                        subnet_plan_q.push_back(r);
                        produced++;
                        addr = addr + blk;
                    end
                end
            end
        end
        stored_cnt = 0;
        space_total = '0;
        dropped = 1'b0;
    endtask

    // request sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            host_count <= '0;
            last_request <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
                plan_request(host_count, last_request);
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (req_q.size() > 0)
                begin
                    next_req = req_q.pop_front();
                    host_count <= next_req.hosts;
                    last_request <= next_req.last;
                    req_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result receiver stall pattern, with one long hold-off while requests are still queued
    always @(posedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= 60 && res_valid && req_q.size() > 8)
        begin
            hold_done = 1'b1;
            hold_left = 400;
            res_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 150);
            end
            else
                mode_left--;
            case (stall_mode)
                STALL_NONE:   res_stall <= 1'b0;
                STALL_LIGHT:  res_stall <= ($urandom_range(0, 99) < 30);
                STALL_HEAVY:  res_stall <= ($urandom_range(0, 99) < 80);
                default:      res_stall <= ~res_stall;
            endcase
        end
    end

    task automatic check_field(input string name, input logic [ADDR_W-1:0] exp_v,
                               input logic [ADDR_W-1:0] got_v);
        if (exp_v !== got_v)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("result %0d: %s expected %h got %h", results_seen, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (subnet_plan_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("result %0d: none expected, got subnet %0d at %h",
                             results_seen, subnet_index, network_addr);
            end
            else
            begin
                want = subnet_plan_q.pop_front();
                check_field("subnet_index", 32'(want.idx), 32'(subnet_index));
                check_field("network_addr", want.net_addr, network_addr);
                check_field("first_host", want.lo_host, first_host);
                check_field("final_host", want.hi_host, final_host);
                check_field("broadcast_addr", want.bcast, broadcast_addr);
                check_field("subnet_mask", want.mask, subnet_mask);
                check_field("fits", 32'(want.fit), 32'(fits));
                check_field("overflowed", 32'(want.ovf), 32'(overflowed));
                check_field("end_of_plan", 32'(want.eop), 32'(end_of_plan));
            end
            results_seen++;
        end
    end

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_BASE_ADDR)
            plan_base = val;
        else
            plan_prefix = val[PREFIX_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_network(input logic [ADDR_W-1:0] base, input logic [PREFIX_W-1:0] pfx);
        write_cfg(REG_BASE_ADDR, base);
        write_cfg(REG_PREFIX_LEN, ADDR_W'(pfx));
    endtask

    task automatic push_req(input logic [HOST_W-1:0] hosts, input logic last);
        subnet_req_t q;
        q.hosts = hosts;
        q.last = last;
        req_q.push_back(q);
    endtask

    // all requests taken, all results seen, then let the block settle
    task automatic drain();
        while (req_q.size() != 0 || req_valid || subnet_plan_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one plan of n requests; width_hi steers host counts towards plans that fit
    task automatic add_plan(input int n, input int width_hi);
        int          w;
        logic [23:0] top;
        logic [23:0] hosts;
        for (int i = 0; i < n; i++)
        begin
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 24) : $urandom_range(0, width_hi);
            top = (w >= 24) ? 24'hFF_FFFF : 24'((32'd1 << w) - 1);
            case ($urandom_range(0, 3))
                0:       hosts = top;
                1:       hosts = (w == 0) ? 24'd0 : top - 24'd1;
                default: hosts = 24'($urandom) & top;
            endcase
            push_req(hosts, i == n - 1);
        end
    endtask

    initial
    begin
        int          sent;
        int          phase;
        int          phase_items;
        int          n;
        int          width_hi;
        logic [4:0]  pfx;
        logic [31:0] base;
        sent = 0;
        phase = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset network (base 0, /24): mixed sizes incl. zero hosts, then an oversized plan
        push_req(24'd0, 1'b0);
        push_req(24'd1, 1'b0);
        push_req(24'd2, 1'b0);
        push_req(24'd62, 1'b0);
        push_req(24'd30, 1'b0);
        push_req(24'd5, 1'b1);
        push_req(24'hFF_FFFF, 1'b1);
        drain();

        // whole address space, host bits of base all cleared
        set_network(32'hFFFF_FFFF, 5'd0);
        push_req(24'hFF_FFFF, 1'b0);
        push_req(24'hFF_FFFE, 1'b0);
        push_req(24'h80_0000, 1'b0);
        push_req(24'h55_5555, 1'b0);
        push_req(24'hAA_AAAA, 1'b0);
        push_req(24'd1, 1'b1);
        drain();

        // /31: a lone two-address block fits exactly, two do not
        set_network(32'hC0A8_01FF, 5'd31);
        push_req(24'd0, 1'b1);
        push_req(24'd0, 1'b0);
        push_req(24'd0, 1'b1);
        drain();

        // exact fit of the /24 and one past it
        set_network(32'h1234_5678, 5'd24);
        push_req(24'd254, 1'b1);
        push_req(24'd255, 1'b1);
        drain();

        while (sent < RANDOM_ITEMS)
        begin
            case (phase % 7)
                0:       pfx = 5'd8;
                1:       pfx = 5'd24;
                2:       pfx = 5'd0;
                3:       pfx = 5'd31;
                4:       pfx = 5'd16;
                5:       pfx = 5'($urandom_range(8, 24));
                default: pfx = 5'($urandom_range(0, 31));
            endcase
            case ($urandom_range(0, 3))
                0:       base = 32'd0;
                1:       base = 32'hFFFF_FFFF;
                default: base = $urandom;
            endcase
            set_network(base, pfx);
            width_hi = 32 - pfx - 4;
            if (width_hi < 0)
                width_hi = 0;
            if (width_hi > 24)
                width_hi = 24;
            phase_items = 0;
            while (phase_items < 45)
            begin
                // now and then more requests than the store holds
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 10);
                add_plan(n, width_hi);
                phase_items += n;
            end
            sent += phase_items;
            phase++;
            drain();
        end

        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
